[rtl/a64enc_pkg.sv]
// ---------------------------------------------------------------------------
// a64enc_pkg
// Operation codes, error codes, base opcodes and packing helpers for the
// aarch64 instruction encoder
// ---------------------------------------------------------------------------
package a64enc_pkg;

    localparam int unsigned OpWidth   = 5;
    localparam int unsigned RegWidth  = 5;
    localparam int unsigned CondWidth = 4;
    localparam int unsigned HwWidth   = 2;
    localparam int unsigned OffWidth  = 32;
    localparam int unsigned ValWidth  = 64;
    localparam int unsigned WordWidth = 32;
    localparam int unsigned ErrWidth  = 3;
    localparam int unsigned InWidth   = 128;

    // operation codes
    localparam logic [OpWidth-1:0] OP_MOVZ    = 5'd0;
    localparam logic [OpWidth-1:0] OP_MOVK    = 5'd1;
    localparam logic [OpWidth-1:0] OP_CONST64 = 5'd2;
    localparam logic [OpWidth-1:0] OP_MOVREG  = 5'd3;
    localparam logic [OpWidth-1:0] OP_ADDREG  = 5'd4;
    localparam logic [OpWidth-1:0] OP_SUBREG  = 5'd5;
    localparam logic [OpWidth-1:0] OP_MUL     = 5'd6;
    localparam logic [OpWidth-1:0] OP_SDIV    = 5'd7;
    localparam logic [OpWidth-1:0] OP_MSUB    = 5'd8;
    localparam logic [OpWidth-1:0] OP_NEG     = 5'd9;
    localparam logic [OpWidth-1:0] OP_ADDIMM  = 5'd10;
    localparam logic [OpWidth-1:0] OP_SUBIMM  = 5'd11;
    localparam logic [OpWidth-1:0] OP_CMP     = 5'd12;
    localparam logic [OpWidth-1:0] OP_CSET    = 5'd13;
    localparam logic [OpWidth-1:0] OP_STRPRE  = 5'd14;
    localparam logic [OpWidth-1:0] OP_LDRPOST = 5'd15;
    localparam logic [OpWidth-1:0] OP_STUR    = 5'd16;
    localparam logic [OpWidth-1:0] OP_LDUR    = 5'd17;
    localparam logic [OpWidth-1:0] OP_STPPRE  = 5'd18;
    localparam logic [OpWidth-1:0] OP_LDPPOST = 5'd19;
    localparam logic [OpWidth-1:0] OP_B       = 5'd20;
    localparam logic [OpWidth-1:0] OP_BCOND   = 5'd21;
    localparam logic [OpWidth-1:0] OP_CBZ     = 5'd22;
    localparam logic [OpWidth-1:0] OP_CBNZ    = 5'd23;
    localparam logic [OpWidth-1:0] OP_BL      = 5'd24;
    localparam logic [OpWidth-1:0] OP_BLR     = 5'd25;
    localparam logic [OpWidth-1:0] OP_RET     = 5'd26;

    // error codes
    localparam logic [ErrWidth-1:0] ERR_OK       = 3'd0;
    localparam logic [ErrWidth-1:0] ERR_IMM9     = 3'd1;
    localparam logic [ErrWidth-1:0] ERR_PAIR_AL  = 3'd2;
    localparam logic [ErrWidth-1:0] ERR_PAIR_RNG = 3'd3;
    localparam logic [ErrWidth-1:0] ERR_IMM12    = 3'd4;
    localparam logic [ErrWidth-1:0] ERR_IMM26    = 3'd5;
    localparam logic [ErrWidth-1:0] ERR_IMM19    = 3'd6;
    localparam logic [ErrWidth-1:0] ERR_BAD_OP   = 3'd7;

    // base opcodes
    localparam logic [WordWidth-1:0] BASE_MOVZ    = 32'hD280_0000;
    localparam logic [WordWidth-1:0] BASE_MOVK    = 32'hF280_0000;
    localparam logic [WordWidth-1:0] BASE_ORR     = 32'hAA00_0000;
    localparam logic [WordWidth-1:0] BASE_ADD     = 32'h8B00_0000;
    localparam logic [WordWidth-1:0] BASE_SUB     = 32'hCB00_0000;
    localparam logic [WordWidth-1:0] BASE_MADD    = 32'h9B00_0000;
    localparam logic [WordWidth-1:0] BASE_SDIV    = 32'h9AC0_0C00;
    localparam logic [WordWidth-1:0] BASE_MSUB    = 32'h9B00_8000;
    localparam logic [WordWidth-1:0] BASE_ADDIMM  = 32'h9100_0000;
    localparam logic [WordWidth-1:0] BASE_SUBIMM  = 32'hD100_0000;
    localparam logic [WordWidth-1:0] BASE_SUBS    = 32'hEB00_0000;
    localparam logic [WordWidth-1:0] BASE_CSINC   = 32'h9A80_0400;
    localparam logic [WordWidth-1:0] BASE_STRPRE  = 32'hF800_0C00;
    localparam logic [WordWidth-1:0] BASE_LDRPOST = 32'hF840_0400;
    localparam logic [WordWidth-1:0] BASE_STUR    = 32'hF800_0000;
    localparam logic [WordWidth-1:0] BASE_LDUR    = 32'hF840_0000;
    localparam logic [WordWidth-1:0] BASE_STP     = 32'hA980_0000;
    localparam logic [WordWidth-1:0] BASE_LDP     = 32'hA8C0_0000;
    localparam logic [WordWidth-1:0] BASE_B       = 32'h1400_0000;
    localparam logic [WordWidth-1:0] BASE_BL      = 32'h9400_0000;
    localparam logic [WordWidth-1:0] BASE_BCOND   = 32'h5400_0000;
    localparam logic [WordWidth-1:0] BASE_CBZ     = 32'hB400_0000;
    localparam logic [WordWidth-1:0] BASE_CBNZ    = 32'hB500_0000;
    localparam logic [WordWidth-1:0] BASE_BLR     = 32'hD63F_0000;
    localparam logic [WordWidth-1:0] BASE_RET     = 32'hD65F_0000;

    localparam logic [RegWidth-1:0] REG_ZR = 5'd31;
    localparam logic [RegWidth-1:0] REG_LR = 5'd30;

    typedef struct packed {
        logic [ValWidth-1:0]  value;
        logic [OffWidth-1:0]  offset;
        logic [HwWidth-1:0]   halfword;
        logic [CondWidth-1:0] condition;
        logic [RegWidth-1:0]  third_reg;
        logic [RegWidth-1:0]  second_src;
        logic [RegWidth-1:0]  first_src;
        logic [RegWidth-1:0]  dest_reg;
        logic [OpWidth-1:0]   operation;
    } req_t;

    function automatic logic [WordWidth-1:0] pack_rrr(
        input logic [WordWidth-1:0] base,
        input logic [RegWidth-1:0]  rd,
        input logic [RegWidth-1:0]  rn,
        input logic [RegWidth-1:0]  rm
    );
        return base | {11'd0, rm, 6'd0, rn, rd};
    endfunction

    function automatic logic [WordWidth-1:0] pack_wide(
        input logic [WordWidth-1:0] base,
        input logic [RegWidth-1:0]  rd,
        input logic [15:0]          imm16,
        input logic [HwWidth-1:0]   hw
    );
        return base | {9'd0, hw, imm16, rd};
    endfunction

    // true when the top bits from msb down to pos are all equal (signed fit)
    function automatic logic fits_signed(
        input logic [OffWidth-1:0] off,
        input logic [OffWidth-1:0] top_mask
    );
        return ((off & top_mask) == top_mask) || ((off & top_mask) == '0);
    endfunction

endpackage

[rtl/aarch64_instruction_encoder.sv]
// ---------------------------------------------------------------------------
// aarch64_instruction_encoder
// Encodes one request into one to four aarch64 instruction words with
// immediate range checks
// ---------------------------------------------------------------------------
//  channel | ports     | tdata                          | tuser  | tlast
//  request | s_axis_*  | op,rd,rn,rm,r3,cond,hw,off,val | -      | -
//  result  | m_axis_*  | word                           | error  | last word
//
// one request per cycle for single-word forms while results are not stalled;
// const64 emits one to four words while the request register holds it. a
// request passes the request register, then the result register. reset
// clears the valid flags, halfword mask and first-word flag. a stalled result
// register holds its word while the request register keeps the next request waiting.
module aarch64_instruction_encoder (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // operation, dest_reg, first_src, second_src, third_reg, condition,
    // halfword, offset, value, zero pad
    input  logic [a64enc_pkg::InWidth-1:0]       s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // word
    output logic [a64enc_pkg::WordWidth-1:0]     m_axis_tdata,
    // error
    output logic [a64enc_pkg::ErrWidth-1:0]      m_axis_tuser,
    output logic                                 m_axis_tlast
);
    import a64enc_pkg::*;

    req_t                  req_in;
    req_t                  req_reg;
    logic                  in_valid_reg, in_valid_next;
    logic [3:0]            mask_reg, mask_next;
    logic                  first_reg, first_next;
    logic                  m_valid_reg, m_valid_next;
    logic [WordWidth-1:0]  m_word_reg;
    logic [ErrWidth-1:0]   m_err_reg;
    logic                  m_last_reg;

    logic [WordWidth-1:0]  word_c;
    logic [ErrWidth-1:0]   err_c;
    logic                  last_c;
    logic [3:0]            init_mask;
    logic [3:0]            low_bit;
    logic [HwWidth-1:0]    chunk_idx;
    logic [15:0]           chunk;
    logic                  out_load;
    logic                  in_done;
    logic                  s_accept;
    logic [OffWidth-1:0]   ou;

    assign req_in = req_t'(s_axis_tdata[$bits(req_t)-1:0]);
    assign ou     = req_reg.offset;

    assign init_mask = {|s_axis_tdata[126:111], |s_axis_tdata[110:95],
                        |s_axis_tdata[94:79],   |s_axis_tdata[78:63]};
    assign low_bit   = mask_reg & (~mask_reg + 4'd1);

    always_comb begin
        case (low_bit)
            4'b0010: chunk_idx = 2'd1;
            4'b0100: chunk_idx = 2'd2;
            4'b1000: chunk_idx = 2'd3;
            default: chunk_idx = 2'd0;
        endcase
    end

    always_comb begin
        case (chunk_idx)
            2'd1:    chunk = req_reg.value[31:16];
            2'd2:    chunk = req_reg.value[47:32];
            2'd3:    chunk = req_reg.value[63:48];
            default: chunk = req_reg.value[15:0];
        endcase
    end

    always_comb begin
        word_c = '0;
        err_c  = ERR_OK;
        last_c = 1'b1;
        case (req_reg.operation)
            OP_MOVZ: word_c = pack_wide(BASE_MOVZ, req_reg.dest_reg,
                                        req_reg.value[15:0], req_reg.halfword);
            OP_MOVK: word_c = pack_wide(BASE_MOVK, req_reg.dest_reg,
                                        req_reg.value[15:0], req_reg.halfword);
            OP_CONST64: begin
                if (mask_reg == 4'd0) begin
                    word_c = pack_wide(BASE_MOVZ, req_reg.dest_reg, 16'd0, 2'd0);
                end else begin
                    word_c = pack_wide(first_reg ? BASE_MOVZ : BASE_MOVK,
                                       req_reg.dest_reg, chunk, chunk_idx);
                    last_c = ((mask_reg & ~low_bit) == 4'd0);
                end
            end
            OP_MOVREG: word_c = pack_rrr(BASE_ORR, req_reg.dest_reg, REG_ZR,
                                         req_reg.second_src);
            OP_ADDREG: word_c = pack_rrr(BASE_ADD, req_reg.dest_reg, req_reg.first_src,
                                         req_reg.second_src);
            OP_SUBREG: word_c = pack_rrr(BASE_SUB, req_reg.dest_reg, req_reg.first_src,
                                         req_reg.second_src);
            OP_MUL: word_c = pack_rrr(BASE_MADD, req_reg.dest_reg, req_reg.first_src,
                                      req_reg.second_src) | {17'd0, REG_ZR, 10'd0};
            OP_SDIV: word_c = pack_rrr(BASE_SDIV, req_reg.dest_reg, req_reg.first_src,
                                       req_reg.second_src);
            OP_MSUB: word_c = pack_rrr(BASE_MSUB, req_reg.dest_reg, req_reg.first_src,
                                       req_reg.second_src)
                              | {17'd0, req_reg.third_reg, 10'd0};
            OP_NEG: word_c = pack_rrr(BASE_SUB, req_reg.dest_reg, REG_ZR,
                                      req_reg.second_src);
            OP_ADDIMM, OP_SUBIMM: begin
                if (ou[31:12] != 20'd0) begin
                    err_c = ERR_IMM12;
                end else begin
                    word_c = ((req_reg.operation == OP_ADDIMM) ? BASE_ADDIMM : BASE_SUBIMM)
                             | {10'd0, ou[11:0], req_reg.first_src, req_reg.dest_reg};
                end
            end
            OP_CMP: word_c = pack_rrr(BASE_SUBS, REG_ZR, req_reg.first_src,
                                      req_reg.second_src);
            OP_CSET: word_c = BASE_CSINC | {11'd0, REG_ZR, req_reg.condition ^ 4'd1,
                                            2'd0, REG_ZR, req_reg.dest_reg};
            OP_STRPRE, OP_LDRPOST, OP_STUR, OP_LDUR: begin
                if (!fits_signed(ou, 32'hFFFF_FF00)) begin
                    err_c = ERR_IMM9;
                end else begin
                    case (req_reg.operation)
                        OP_STRPRE:  word_c = BASE_STRPRE;
                        OP_LDRPOST: word_c = BASE_LDRPOST;
                        OP_STUR:    word_c = BASE_STUR;
                        default:    word_c = BASE_LDUR;
                    endcase
                    word_c = word_c | {11'd0, ou[8:0], 2'd0, req_reg.first_src,
                                       req_reg.dest_reg};
                end
            end
            OP_STPPRE, OP_LDPPOST: begin
                if (ou[2:0] != 3'd0) begin
                    err_c = ERR_PAIR_AL;
                end else if (!fits_signed(ou, 32'hFFFF_FE00)) begin
                    err_c = ERR_PAIR_RNG;
                end else begin
                    word_c = ((req_reg.operation == OP_STPPRE) ? BASE_STP : BASE_LDP)
                             | {10'd0, ou[9:3], req_reg.third_reg, req_reg.first_src,
                                req_reg.dest_reg};
                end
            end
            OP_B, OP_BL: begin
                if (!fits_signed(ou, 32'hFE00_0000)) begin
                    err_c = ERR_IMM26;
                end else begin
                    word_c = ((req_reg.operation == OP_B) ? BASE_B : BASE_BL)
                             | {6'd0, ou[25:0]};
                end
            end
            OP_BCOND, OP_CBZ, OP_CBNZ: begin
                if (!fits_signed(ou, 32'hFFFC_0000)) begin
                    err_c = ERR_IMM19;
                end else if (req_reg.operation == OP_BCOND) begin
                    word_c = BASE_BCOND | {8'd0, ou[18:0], 1'b0, req_reg.condition};
                end else begin
                    word_c = ((req_reg.operation == OP_CBZ) ? BASE_CBZ : BASE_CBNZ)
                             | {8'd0, ou[18:0], req_reg.dest_reg};
                end
            end
            OP_BLR: word_c = BASE_BLR | {22'd0, req_reg.first_src, 5'd0};
            OP_RET: word_c = BASE_RET | {22'd0, REG_LR, 5'd0};
            default: err_c = ERR_BAD_OP;
        endcase
    end

    assign out_load      = in_valid_reg && (!m_valid_reg || m_axis_tready);
    assign in_done       = out_load && last_c;
    assign s_axis_tready = !in_valid_reg || in_done;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        mask_next     = mask_reg;
        first_next    = first_reg;
        m_valid_next  = m_valid_reg;
        if (in_done) begin
            in_valid_next = 1'b0;
        end
        if (out_load) begin
            mask_next  = mask_reg & ~low_bit;
            first_next = 1'b0;
        end
        if (s_accept) begin
            in_valid_next = 1'b1;
            mask_next     = init_mask;
            first_next    = 1'b1;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            mask_reg     <= 4'd0;
            first_reg    <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            mask_reg     <= mask_next;
            first_reg    <= first_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg <= req_in;
        end
        if (out_load) begin
            m_word_reg <= word_c;
            m_err_reg  <= err_c;
            m_last_reg <= last_c;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_word_reg;
    assign m_axis_tuser  = m_err_reg;
    assign m_axis_tlast  = m_last_reg;

    // an error result carries a zero word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_err_reg != ERR_OK) |-> (m_word_reg == '0 && m_last_reg))
        else $error("error result with nonzero word or not last");

    // a non-final word means the request is still held for the rest
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> in_valid_reg)
        else $error("non-final word without a pending request");

    // only the constant load issues more than one word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && req_reg.operation != OP_CONST64) |-> last_c)
        else $error("single-word form not marked last");

    // a constant load word that is not last leaves halfwords to issue
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !last_c) |=> (in_valid_reg && mask_reg != 4'd0))
        else $error("constant load lost its remaining halfwords");

endmodule

[test/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Stream-level check of the aarch64 instruction encoder: directed requests
// for each form but LDRPOST, STUR and CBZ, range edges and error codes,
// then random requests biased toward immediate boundaries, with random
// gaps and back-pressure on both channels. Each result word is compared in
// order against words encoded independently inside the bench.
// ---------------------------------------------------------------------------
module tb_top;
    import a64enc_pkg::*;

    localparam int unsigned CycleLimit     = 100000;
    localparam int unsigned RandomRequests = 75;
    localparam logic [OpWidth-1:0] OP_FIRST_UNDEF = OP_RET + 5'd1;
    localparam logic [OpWidth-1:0] OP_LAST_UNDEF  = '1;

    typedef struct packed {
        logic [WordWidth-1:0] word;
        logic [ErrWidth-1:0]  code;
        logic                 last;
    } insn_word_t;

    typedef struct packed {
        logic drain;
        req_t req;
    } send_item_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [InWidth-1:0]   s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [WordWidth-1:0] m_axis_tdata;
    logic [ErrWidth-1:0]  m_axis_tuser;
    logic                 m_axis_tlast;

    send_item_t  send_queue[$];
    insn_word_t  words_due[$];
    insn_word_t  want;
    logic        req_taken = 1'b0;
    logic        calm;
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned reqs_sent = 0;
    int unsigned words_seen = 0;
    int unsigned error_words = 0;
    int unsigned multi_loads = 0;
    int          send_gap = 0;
    int          stall_left = 0;

    aarch64_instruction_encoder dut (.*);

    always #2 aclk = ~aclk;

    // stretches with no idling on either side
    assign calm = (cycle_count % 600) >= 450;

    function automatic void due_word(input logic [31:0] w, input logic [2:0] c,
                                     input logic l);
        words_due.insert(words_due.size(), insn_word_t'{word: w, code: c, last: l});
    endfunction

    function automatic void queue_item(input logic drain, input req_t r);
        send_queue.insert(send_queue.size(), send_item_t'{drain: drain, req: r});
    endfunction

    function automatic void encode_request(input req_t r);
        logic [31:0] rd, rn, rm, r3, cond, zr, lr, ou, chunk, w;
        int          so, top, n, h;
        rd = 32'(r.dest_reg);
        rn = 32'(r.first_src);
        rm = 32'(r.second_src);
        r3 = 32'(r.third_reg);
        cond = 32'(r.condition);
        zr = 32'(REG_ZR);
        lr = 32'(REG_LR);
        ou = r.offset;
        so = $signed(r.offset);
        case (r.operation)
            OP_MOVZ, OP_MOVK: begin
                w = (r.operation == OP_MOVZ) ? BASE_MOVZ : BASE_MOVK;
                chunk = 32'(r.value[15:0]);
                due_word(w | (32'(r.halfword) << 21) | (chunk << 5) | rd, ERR_OK, 1'b1);
            end
            OP_CONST64: begin
                top = -1;
                for (h = 0; h < 4; h++)
                    if (r.value[16*h +: 16] != 16'd0) top = h;
                if (top < 0) begin
                    due_word(BASE_MOVZ | rd, ERR_OK, 1'b1);
                end else begin
                    n = 0;
                    for (h = 0; h < 4; h++) begin
                        chunk = 32'(r.value[16*h +: 16]);
                        if (chunk != 0) begin
                            w = (n == 0) ? BASE_MOVZ : BASE_MOVK;
                            due_word(w | (h << 21) | (chunk << 5) | rd, ERR_OK, h == top);
                            n++;
                        end
                    end
                    if (n > 1) multi_loads++;
                end
            end
            OP_MOVREG: due_word(BASE_ORR | (rm << 16) | (zr << 5) | rd, ERR_OK, 1'b1);
            OP_ADDREG: due_word(BASE_ADD | (rm << 16) | (rn << 5) | rd, ERR_OK, 1'b1);
            OP_SUBREG: due_word(BASE_SUB | (rm << 16) | (rn << 5) | rd, ERR_OK, 1'b1);
            OP_MUL:
                due_word(BASE_MADD | (rm << 16) | (zr << 10) | (rn << 5) | rd, ERR_OK, 1'b1);
            OP_SDIV: due_word(BASE_SDIV | (rm << 16) | (rn << 5) | rd, ERR_OK, 1'b1);
            OP_MSUB:
                due_word(BASE_MSUB | (rm << 16) | (r3 << 10) | (rn << 5) | rd, ERR_OK, 1'b1);
            OP_NEG: due_word(BASE_SUB | (rm << 16) | (zr << 5) | rd, ERR_OK, 1'b1);
            OP_ADDIMM, OP_SUBIMM: begin
                w = (r.operation == OP_ADDIMM) ? BASE_ADDIMM : BASE_SUBIMM;
                // negative offsets read as large unsigned values
                if (ou > 32'd4095) due_word('0, ERR_IMM12, 1'b1);
                else due_word(w | (ou << 10) | (rn << 5) | rd, ERR_OK, 1'b1);
            end
            OP_CMP: due_word(BASE_SUBS | (rm << 16) | (rn << 5) | zr, ERR_OK, 1'b1);
            OP_CSET:
                due_word(BASE_CSINC | (zr << 16) | ((cond ^ 32'd1) << 12) | (zr << 5) | rd,
                         ERR_OK, 1'b1);
            OP_STRPRE, OP_LDRPOST, OP_STUR, OP_LDUR: begin
                case (r.operation)
                    OP_STRPRE:  w = BASE_STRPRE;
                    OP_LDRPOST: w = BASE_LDRPOST;
                    OP_STUR:    w = BASE_STUR;
                    default:    w = BASE_LDUR;
                endcase
                if (so < -256 || so > 255) due_word('0, ERR_IMM9, 1'b1);
                else due_word(w | ((ou & 32'h1FF) << 12) | (rn << 5) | rd, ERR_OK, 1'b1);
            end
            OP_STPPRE, OP_LDPPOST: begin
                w = (r.operation == OP_STPPRE) ? BASE_STP : BASE_LDP;
                // alignment is checked ahead of range
                if (ou[2:0] != 3'd0) due_word('0, ERR_PAIR_AL, 1'b1);
                else if (so < -512 || so > 504) due_word('0, ERR_PAIR_RNG, 1'b1);
                else due_word(w | (((ou >> 3) & 32'h7F) << 15) | (r3 << 10) | (rn << 5) | rd,
                              ERR_OK, 1'b1);
            end
            OP_B, OP_BL: begin
                w = (r.operation == OP_B) ? BASE_B : BASE_BL;
                if (so < -(1 << 25) || so >= (1 << 25)) due_word('0, ERR_IMM26, 1'b1);
                else due_word(w | (ou & 32'h03FF_FFFF), ERR_OK, 1'b1);
            end
            OP_BCOND, OP_CBZ, OP_CBNZ: begin
                case (r.operation)
                    OP_BCOND: w = BASE_BCOND | cond;
                    OP_CBZ:   w = BASE_CBZ | rd;
                    default:  w = BASE_CBNZ | rd;
                endcase
                if (so < -(1 << 18) || so >= (1 << 18)) due_word('0, ERR_IMM19, 1'b1);
                else due_word(w | ((ou & 32'h0007_FFFF) << 5), ERR_OK, 1'b1);
            end
            OP_BLR: due_word(BASE_BLR | (rn << 5), ERR_OK, 1'b1);
            OP_RET: due_word(BASE_RET | (lr << 5), ERR_OK, 1'b1);
            default: due_word('0, ERR_BAD_OP, 1'b1);
        endcase
    endfunction

    function automatic int pick_gap();
        int k;
        if (calm) return 0;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // offsets clustered around the legal range of each form
    function automatic logic [31:0] pick_offset(input logic [OpWidth-1:0] op);
        int lo, hi, step, k;
        step = 1;
        case (op)
            OP_ADDIMM, OP_SUBIMM: begin
                lo = 0;
                hi = 4095;
            end
            OP_STRPRE, OP_LDRPOST, OP_STUR, OP_LDUR: begin
                lo = -256;
                hi = 255;
            end
            OP_STPPRE, OP_LDPPOST: begin
                lo = -512;
                hi = 504;
                step = 8;
            end
            OP_B, OP_BL: begin
                lo = -(1 << 25);
                hi = (1 << 25) - 1;
            end
            OP_BCOND, OP_CBZ, OP_CBNZ: begin
                lo = -(1 << 18);
                hi = (1 << 18) - 1;
            end
            default: return $urandom;
        endcase
        k = $urandom_range(0, 9);
        if (k < 3) return $urandom;
        if (k < 7) return lo + step * $urandom_range(0, (hi - lo) / step);
        case ($urandom_range(0, 4))
            0: return lo - step;
            1: return lo;
            2: return hi;
            3: return hi + step;
            default: return lo + step * $urandom_range(0, (hi - lo) / step) + step / 2;
        endcase
    endfunction

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        int          h;
        v = {$urandom, $urandom};
        for (h = 0; h < 4; h++)
            if ($urandom_range(0, 2) == 0) v[16*h +: 16] = 16'd0;
        return v;
    endfunction

    function automatic logic [OpWidth-1:0] pick_op();
        int k;
        k = $urandom_range(0, 99);
        if (k < 5) return OpWidth'($urandom_range(OP_FIRST_UNDEF, OP_LAST_UNDEF));
        if (k < 20) return OP_CONST64;
        return OpWidth'($urandom_range(OP_MOVZ, OP_RET));
    endfunction

    function automatic req_t random_req(input logic [OpWidth-1:0] op);
        req_t r;
        r.operation  = op;
        r.dest_reg   = RegWidth'($urandom_range(0, 31));
        r.first_src  = RegWidth'($urandom_range(0, 31));
        r.second_src = RegWidth'($urandom_range(0, 31));
        r.third_reg  = RegWidth'($urandom_range(0, 31));
        r.condition  = CondWidth'($urandom_range(0, 15));
        r.halfword   = HwWidth'($urandom_range(0, 3));
        r.offset     = pick_offset(op);
        r.value      = pick_value();
        return r;
    endfunction

    function automatic void queue_fixed(input logic [OpWidth-1:0] op, input logic [31:0] off,
                                        input logic [63:0] val, input logic [3:0] cond);
        req_t r;
        r = random_req(op);
        r.offset = off;
        r.value = val;
        r.condition = cond;
        queue_item(1'b0, r);
    endfunction

    // request driver
    always @(negedge aclk) begin
        if (aresetn && (!s_axis_tvalid || req_taken)) begin
            if (req_taken) send_gap = pick_gap();
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (send_queue.size() != 0 &&
                         !(send_queue[0].drain && words_due.size() != 0)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {1'b0, send_queue[0].req};
                void'(send_queue.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    // request capture and result monitor
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        req_taken <= aresetn && s_axis_tvalid && s_axis_tready;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            encode_request(s_axis_tdata[InWidth-2:0]);
            reqs_sent++;
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            words_seen++;
            if (m_axis_tuser != ERR_OK) error_words++;
            if (words_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h error %0d last %0b", m_axis_tdata,
                             m_axis_tuser, m_axis_tlast);
            end else begin
                want = words_due.pop_front();
                if (m_axis_tdata !== want.word || m_axis_tuser !== want.code ||
                    m_axis_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                                 want.word, want.code, want.last,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
            end
        end
    end

    initial begin : stimulus
        logic [OpWidth-1:0] op;
        int                 i;
        queue_fixed(OP_MOVZ, $urandom, '1, 4'd0);
        queue_fixed(OP_MOVK, $urandom, 64'hFFFF_FFFF_FFFF_0000, 4'd0);
        queue_fixed(OP_CONST64, $urandom, 64'd0, 4'd0);
        queue_fixed(OP_CONST64, $urandom, '1, 4'd0);
        queue_fixed(OP_CONST64, $urandom, 64'h0001_0000_0000_0000, 4'd0);
        for (op = OP_MOVREG; op <= OP_NEG; op++)
            queue_fixed(op, $urandom, pick_value(), 4'd0);
        queue_fixed(OP_ADDIMM, 32'd4095, '0, 4'd0);
        queue_fixed(OP_SUBIMM, 32'hFFFF_FFFF, '0, 4'd0);
        queue_fixed(OP_CMP, $urandom, '0, 4'd0);
        queue_fixed(OP_CSET, $urandom, '0, 4'd15);
        queue_fixed(OP_BCOND, -(1 << 18), '0, 4'd14);
        queue_fixed(OP_STRPRE, -256, '0, 4'd0);
        queue_fixed(OP_LDUR, 32'd256, '0, 4'd0);
        queue_fixed(OP_STPPRE, -512, '0, 4'd0);
        queue_fixed(OP_LDPPOST, 32'd4, '0, 4'd0);
        queue_fixed(OP_STPPRE, 32'd512, '0, 4'd0);
        queue_fixed(OP_B, (1 << 25) - 1, '0, 4'd0);
        queue_fixed(OP_BL, 1 << 25, '0, 4'd0);
        queue_fixed(OP_CBNZ, 1 << 18, '0, 4'd0);
        queue_fixed(OP_BLR, $urandom, '0, 4'd0);
        queue_fixed(OP_RET, $urandom, '0, 4'd0);
        queue_fixed(OP_FIRST_UNDEF, $urandom, '0, 4'd0);
        queue_fixed(OP_LAST_UNDEF, $urandom, '0, 4'd0);
        // some random requests wait until the pipeline has drained
        for (i = 0; i < RandomRequests; i++)
            queue_item(i % 35 == 0, random_req(pick_op()));

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        while (send_queue.size() != 0 || s_axis_tvalid || words_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("%0d requests encoded into %0d words (%0d error results, %0d multi-word loads)",
                 reqs_sent, words_seen, error_words, multi_loads);
        $display("%0d mismatches in %0d cycles", mismatches, cycle_count);
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CycleLimit) @(posedge aclk);
        $display("timeout with %0d words outstanding", words_due.size());
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

[filelist.f]
rtl/a64enc_pkg.sv
rtl/aarch64_instruction_encoder.sv
test/tb_top.sv
